// ----- hw/rtl/tts_pkg.sv -----
// Shared types and constants of the thresholded top-N selector.
`timescale 1ns / 1ps

package tts_pkg;

	// Fixed field and register widths
	localparam int SCORE_W         = 8;
	localparam int KEEP_W          = 4;
	localparam int THRESHOLD_W     = 9;
	localparam int CFG_ADDR_W      = 1;
	localparam int CFG_DATA_W      = 9;

	// Register indexes on the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_KEEP_COUNT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 1'b1;

	// Register reset values
	localparam logic [KEEP_W-1:0]      KEEP_RST      = 4'd8;
	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 9'd0;

	// Per-beat control broadcast to every sort cell
	typedef struct packed {
		logic step;   // input beat accepted
		logic flush;  // beat is the last of its vector
		logic pass;   // score at or above the threshold
	} tts_ctrl_t;

endpackage

// ----- hw/rtl/tts_sort_cell.sv -----
// One cell of the sorted insertion chain: holds one (score, position) pair.
`timescale 1ns / 1ps

module tts_sort_cell #(
	parameter int PosW = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tts_pkg::tts_ctrl_t          ctrl,
	input  logic [tts_pkg::SCORE_W-1:0] new_score,
	input  logic [PosW-1:0]             new_pos,
	input  logic                        cap_ok,
	input  logic                        up_vld,
	input  logic                        up_beat,
	input  logic [tts_pkg::SCORE_W-1:0] up_score,
	input  logic [PosW-1:0]             up_pos,
	output logic                        vld,
	output logic                        beat,
	output logic [tts_pkg::SCORE_W-1:0] score,
	output logic [PosW-1:0]             pos,
	output logic                        nxt_vld,
	output logic [tts_pkg::SCORE_W-1:0] nxt_score,
	output logic [PosW-1:0]             nxt_pos
);
	import tts_pkg::*;

	logic                vld_q;
	logic [SCORE_W-1:0]  score_q;
	logic [PosW-1:0]     pos_q;

	// Entry counts only while it sits inside the current capacity
	assign vld = vld_q & cap_ok;

	// New pair ranks above this entry (an empty entry is always beaten)
	assign beat = !vld || (new_score > score_q) ||
		((new_score == score_q) && (new_pos >= pos_q));

	// Next content: shift from above, take the new pair, or keep
	always_comb begin
		nxt_vld   = vld;
		nxt_score = score_q;
		nxt_pos   = pos_q;
		if (ctrl.pass && beat) begin
			if (up_beat) begin
				nxt_vld   = up_vld & cap_ok;
				nxt_score = up_score;
				nxt_pos   = up_pos;
			end else begin
				nxt_vld   = cap_ok;
				nxt_score = new_score;
				nxt_pos   = new_pos;
			end
		end
	end

	// Valid bit: cleared at the end of each vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.step) begin
			vld_q <= nxt_vld & !ctrl.flush;
		end
	end

	// Pair payload
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			score_q <= nxt_score;
			pos_q   <= nxt_pos;
		end
	end

	assign score = score_q;
	assign pos   = pos_q;

endmodule

// ----- hw/rtl/tts_out_cell.sv -----
// One cell of the result drain chain: loads in parallel, shifts towards the output.
`timescale 1ns / 1ps

module tts_out_cell #(
	parameter int PosW = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        shift,
	input  logic                        ld_vld,
	input  logic                        ld_found,
	input  logic [tts_pkg::SCORE_W-1:0] ld_score,
	input  logic [PosW-1:0]             ld_pos,
	input  logic                        dn_vld,
	input  logic                        dn_found,
	input  logic [tts_pkg::SCORE_W-1:0] dn_score,
	input  logic [PosW-1:0]             dn_pos,
	output logic                        vld,
	output logic                        found,
	output logic [tts_pkg::SCORE_W-1:0] score,
	output logic [PosW-1:0]             pos
);
	import tts_pkg::*;

	logic                vld_q;
	logic                found_q;
	logic [SCORE_W-1:0]  score_q;
	logic [PosW-1:0]     pos_q;

	// Occupancy: a load of a new list wins over a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= ld_vld;
		end else if (shift) begin
			vld_q <= dn_vld;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= ld_found;
			score_q <= ld_score;
			pos_q   <= ld_pos;
		end else if (shift) begin
			found_q <= dn_found;
			score_q <= dn_score;
			pos_q   <= dn_pos;
		end
	end

	assign vld   = vld_q;
	assign found = found_q;
	assign score = score_q;
	assign pos   = pos_q;

endmodule

// ----- hw/rtl/thresholded_top_n_selector_core.sv -----
// Top level of the thresholded top-N selector: sort chain, drain chain and control.
`timescale 1ns / 1ps

// Takes one 8-bit score per cycle and keeps the best (score, position) pairs,
// as many as the keep-count register asks for, in a chain of MAX_RESULTS sort
// cells, each comparing the incoming score against its own entry in parallel,
// so a score is accepted every cycle but for a held-back last beat. On the beat
// marked last the sorted list is copied into a drain chain and the sort chain
// starts empty for the next vector; the first result is offered the cycle
// after the last beat and the list then leaves one result per beat, best first
// (one result with found low if nothing passed the threshold or the keep count
// is zero). Scores keep flowing while a list drains; only a last beat is held
// back (tready low) while the drain chain still holds more than the result
// leaving that cycle, however long the result side holds off.
module thresholded_top_n_selector_core #(
	parameter  int MAX_RESULTS = 8,
	parameter  int MAX_SCORES  = 1024,
	localparam int PosW        = $clog2(MAX_SCORES),
	localparam int TdataW      = ((tts_pkg::SCORE_W + PosW + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_we,
	input  logic [tts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
	// Score input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tts_pkg::SCORE_W-1:0]    s_tdata,  // [7:0] score
	input  logic                           s_tlast,  // last_score
	// Result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [TdataW-1:0]              m_tdata,  // result_score, result_index, zero pad
	output logic                           m_tuser,  // found
	output logic                           m_tlast   // last_result
);
	import tts_pkg::*;

	localparam int PadW = TdataW - SCORE_W - PosW;

	logic [KEEP_W-1:0]        keep_cnt_q;
	logic [THRESHOLD_W-1:0]   threshold_q;
	logic [PosW-1:0]          pos_q;
	tts_ctrl_t                ctrl;
	logic                     drain_free;
	logic                     shift;

	// Sort chain wiring, entry 0 is the virtual cell above the first
	logic [MAX_RESULTS:0]     k_vld;
	logic [MAX_RESULTS:0]     k_beat;
	logic [SCORE_W-1:0]       k_score [MAX_RESULTS+1];
	logic [PosW-1:0]          k_pos   [MAX_RESULTS+1];
	logic [MAX_RESULTS-1:0]   kvld;
	logic [MAX_RESULTS-1:0]   n_vld;
	logic [SCORE_W-1:0]       n_score [MAX_RESULTS];
	logic [PosW-1:0]          n_pos   [MAX_RESULTS];

	// Drain chain wiring, the extra entry is the empty cell past the end
	logic [MAX_RESULTS:0]     d_vld;
	logic [MAX_RESULTS:0]     d_found;
	logic [SCORE_W-1:0]       d_score [MAX_RESULTS+1];
	logic [PosW-1:0]          d_pos   [MAX_RESULTS+1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_cnt_q  <= KEEP_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEEP_COUNT: keep_cnt_q  <= cfg_data[KEEP_W-1:0];
				REG_THRESHOLD:  threshold_q <= cfg_data[THRESHOLD_W-1:0];
				default:        ;
			endcase
		end
	end

	// Handshake: a last beat waits until the drain chain can take a new list
	assign shift      = m_tvalid && m_tready;
	assign drain_free = !d_vld[0] || (m_tready && !d_vld[1]);
	assign s_tready   = drain_free || !s_tlast;

	assign ctrl.step  = s_tvalid && s_tready;
	assign ctrl.flush = s_tvalid && s_tready && s_tlast;
	assign ctrl.pass  = {1'b0, s_tdata} >= threshold_q;

	// Saturating position counter, restarted after each vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctrl.flush) begin
			pos_q <= '0;
		end else if (ctrl.step && (pos_q != PosW'(MAX_SCORES - 1))) begin
			pos_q <= pos_q + PosW'(1);
		end
	end

	assign k_vld[0]   = 1'b0;
	assign k_beat[0]  = 1'b0;
	assign k_score[0] = '0;
	assign k_pos[0]   = '0;

	assign d_vld[MAX_RESULTS]   = 1'b0;
	assign d_found[MAX_RESULTS] = 1'b0;
	assign d_score[MAX_RESULTS] = '0;
	assign d_pos[MAX_RESULTS]   = '0;

	// Cell rows
	for (genvar i = 0; i < MAX_RESULTS; i++) begin : g_cell
		logic                cap_ok;
		logic                ld_vld;
		logic                ld_found;
		logic [SCORE_W-1:0]  ld_score;
		logic [PosW-1:0]     ld_pos;

		assign cap_ok = {{(32 - KEEP_W){1'b0}}, keep_cnt_q} > 32'(i);

		tts_sort_cell #(
			.PosW (PosW)
		) u_sort (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_score (s_tdata),
			.new_pos   (pos_q),
			.cap_ok    (cap_ok),
			.up_vld    (k_vld[i]),
			.up_beat   (k_beat[i]),
			.up_score  (k_score[i]),
			.up_pos    (k_pos[i]),
			.vld       (k_vld[i+1]),
			.beat      (k_beat[i+1]),
			.score     (k_score[i+1]),
			.pos       (k_pos[i+1]),
			.nxt_vld   (n_vld[i]),
			.nxt_score (n_score[i]),
			.nxt_pos   (n_pos[i])
		);

		// First drain cell always carries a result: the empty one if nothing kept
		if (i == 0) begin : g_head
			assign ld_vld   = 1'b1;
			assign ld_found = n_vld[0];
			assign ld_score = n_vld[0] ? n_score[0] : '0;
			assign ld_pos   = n_vld[0] ? n_pos[0] : '0;
		end else begin : g_body
			assign ld_vld   = n_vld[i];
			assign ld_found = 1'b1;
			assign ld_score = n_score[i];
			assign ld_pos   = n_pos[i];
		end

		tts_out_cell #(
			.PosW (PosW)
		) u_out (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (ctrl.flush),
			.shift    (shift),
			.ld_vld   (ld_vld),
			.ld_found (ld_found),
			.ld_score (ld_score),
			.ld_pos   (ld_pos),
			.dn_vld   (d_vld[i+1]),
			.dn_found (d_found[i+1]),
			.dn_score (d_score[i+1]),
			.dn_pos   (d_pos[i+1]),
			.vld      (d_vld[i]),
			.found    (d_found[i]),
			.score    (d_score[i]),
			.pos      (d_pos[i])
		);
	end

	assign kvld = k_vld[MAX_RESULTS:1];

	// Output beat comes from the head of the drain chain
	assign m_tvalid = d_vld[0];
	assign m_tuser  = d_found[0];
	assign m_tlast  = !d_vld[1];
	assign m_tdata  = {{PadW{1'b0}}, d_pos[0], d_score[0]};

	// Kept entries stay packed from the head of the sort chain
	a_sort_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(kvld + MAX_RESULTS'(1)))
		else $error("sort chain has a gap");

	// Drain chain stays packed from the output end
	a_drain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(d_vld[MAX_RESULTS-1:0] + MAX_RESULTS'(1)))
		else $error("drain chain has a gap");

	// A last beat always produces at least one result next cycle
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flush |=> m_tvalid)
		else $error("no result after last beat");

	// Sort chain starts empty after a last beat
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flush |=> (kvld == '0))
		else $error("sort chain not cleared after last beat");

	// Input is only held back for a last beat
	a_stall_last_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s_tlast && d_vld[0]))
		else $error("input stalled without a pending list");

endmodule

// ----- dv/tts_result_checker.sv -----
// Result checker for the thresholded top-N selector: predicts each list and compares every beat.
`timescale 1ns / 1ps

module tts_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tts_pkg::SCORE_W-1:0]    s_tdata,   // [7:0] score
	input  logic                           s_tlast,   // last_score
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [23:0]                    m_tdata,   // [7:0] result_score, [17:8] result_index, zero pad
	input  logic                           m_tuser,   // found
	input  logic                           m_tlast,   // last_result
	output int                             pending_results,
	output int                             mismatches
);
	import tts_pkg::*;

	localparam int KEEP_MAX = 8;
	localparam int POS_W    = 10;
	localparam logic [POS_W-1:0] POS_SAT = 10'd1023;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [POS_W-1:0]   index;
		logic               found;
		logic               closes;
	} ranked_result_t;

	// Model of the ranked list and its registers
	logic [SCORE_W-1:0]       keep_limit_reg;
	logic [THRESHOLD_W-1:0]   floor_reg;
	logic [SCORE_W-1:0]       best_score [KEEP_MAX];
	logic [POS_W-1:0]         best_pos   [KEEP_MAX];
	int                       held;
	logic [POS_W-1:0]         next_pos;

	ranked_result_t           expected_lists[$];
	ranked_result_t           seen;
	ranked_result_t           want;
	ranked_result_t           queued;
	int                       room;
	int                       slot;
	int                       j;
	logic [POS_W-1:0]         this_pos;
	logic [SCORE_W-1:0]       sc;

	// One line per mismatch, counted
	task automatic report(input string what, input int want_v, input int got_v);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_reg = {4'd0, KEEP_RST};
			floor_reg      = THRESHOLD_RST;
			held           = 0;
			next_pos       = '0;
			expected_lists.delete();
			pending_results = 0;
		end else begin
			// result beat against the oldest expectation
			if (m_tvalid && m_tready) begin
				seen = '{m_tdata[7:0], m_tdata[17:8], m_tuser, m_tlast};
				if (expected_lists.size() == 0) begin
					report("unexpected result beat, tdata", 0, m_tdata);
				end else begin
					want = expected_lists.pop_front();
					if (seen.score != want.score)
						report("result_score", want.score, seen.score);
					if (seen.index != want.index)
						report("result_index", want.index, seen.index);
					if (seen.found != want.found)
						report("found", want.found, seen.found);
					if (seen.closes != want.closes)
						report("last_result", want.closes, seen.closes);
				end
			end

			// register writes
			if (cfg_we) begin
				if (cfg_addr == REG_KEEP_COUNT)
					keep_limit_reg = {4'd0, cfg_data[KEEP_W-1:0]};
				else if (cfg_addr == REG_THRESHOLD)
					floor_reg = cfg_data[THRESHOLD_W-1:0];
			end

			// score beat: insertion into the ranked list
			if (s_tvalid && s_tready) begin
				sc       = s_tdata;
				room     = (keep_limit_reg > KEEP_MAX) ? KEEP_MAX : int'(keep_limit_reg);
				if (held > room)
					held = room;
				this_pos = next_pos;
				if (next_pos != POS_SAT)
					next_pos = next_pos + 1'b1;
				if ({1'b0, sc} >= floor_reg && room > 0) begin
					slot = 0;
					while (slot < held && (best_score[slot] > sc ||
							(best_score[slot] == sc && best_pos[slot] > this_pos)))
						slot++;
					if (slot < room) begin
						j = (held < room) ? held : room - 1;
						while (j > slot) begin
							best_score[j] = best_score[j-1];
							best_pos[j]   = best_pos[j-1];
							j--;
						end
						best_score[slot] = sc;
						best_pos[slot]   = this_pos;
						if (held < room)
							held++;
					end
				end
				// last beat: the list leaves best first, then the state clears
				if (s_tlast) begin
					if (held == 0) begin
						queued = '{'0, '0, 1'b0, 1'b1};
						expected_lists.insert(expected_lists.size(), queued);
					end else begin
						for (int k = 0; k < held; k++) begin
							queued = '{best_score[k], best_pos[k], 1'b1, (k == held - 1)};
							expected_lists.insert(expected_lists.size(), queued);
						end
					end
					held     = 0;
					next_pos = '0;
				end
			end
			pending_results = expected_lists.size();
		end
	end

endmodule

// ----- dv/tb_thresholded_top_n_selector_core.sv -----
// Testbench top for the thresholded top-N selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_thresholded_top_n_selector_core;
	import tts_pkg::*;

	localparam int SETTLE_CYCLES = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SCORE_W-1:0]    s_tdata;   // [7:0] score
	logic                  s_tlast;   // last_score
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // [7:0] result_score, [17:8] result_index, zero pad
	logic                  m_tuser;   // found
	logic                  m_tlast;   // last_result

	int pending_results;
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	int rx_hold_cycles;

	thresholded_top_n_selector_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tts_result_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result side: random back-pressure, or a long hold-off when one is requested
	initial begin
		m_tready       = 1'b0;
		rx_hold_cycles = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Register write; called at a falling edge with the score side idle
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we   <= 1'b0;
		@(negedge clk);
	endtask

	// One score beat, with random gaps in front; returns at the falling edge after the beat
	task automatic send_score(input logic [SCORE_W-1:0] sc, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sc;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop offering, wait for every expected result and let the block settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Score with a fair share of ties and extremes
	function automatic logic [SCORE_W-1:0] pick_score();
		case ($urandom_range(3))
			0: pick_score = $urandom_range(1) ? 8'hff : 8'h00;
			1: pick_score = 8'(($urandom_range(4) * 64) > 255 ? 255 : $urandom_range(4) * 64);
			default: pick_score = $urandom_range(255);
		endcase
	endfunction

	// A well-formed vector of random scores closed by a last beat
	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++)
			send_score(pick_score(), i == len - 1);
	endtask

	// Random settings, biased towards useful ones
	task automatic random_settings();
		int keep;
		int floor_v;
		case ($urandom_range(5))
			0: keep = 0;
			1: keep = $urandom_range(15, 9);
			default: keep = $urandom_range(8, 1);
		endcase
		case ($urandom_range(7))
			0: floor_v = $urandom_range(511, 256);
			1: floor_v = $urandom_range(255, 200);
			default: floor_v = $urandom_range(160);
		endcase
		write_reg(REG_KEEP_COUNT, keep);
		write_reg(REG_THRESHOLD, floor_v);
	endtask

	// Main stimulus
	initial begin
		int sent;
		int len;
		int cut;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 58;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: ties on the top score, both extremes
		send_score(8'd0, 1'b0);
		send_score(8'd255, 1'b0);
		send_score(8'd128, 1'b0);
		send_score(8'd255, 1'b0);
		send_score(8'd0, 1'b1);
		drain_results();

		// threshold above any score: empty list
		write_reg(REG_THRESHOLD, 256);
		send_score(8'd255, 1'b0);
		send_score(8'd200, 1'b1);
		drain_results();
		write_reg(REG_THRESHOLD, 511);
		send_score(8'd255, 1'b1);
		drain_results();

		// nothing kept at all
		write_reg(REG_THRESHOLD, 0);
		write_reg(REG_KEEP_COUNT, 0);
		send_score(8'd10, 1'b0);
		send_score(8'd20, 1'b1);
		drain_results();

		// oversized count acts as the full list; nine scores, one drops out
		write_reg(REG_KEEP_COUNT, 15);
		for (int i = 0; i < 9; i++)
			send_score(8'(i * 29 + 3), i == 8);
		drain_results();

		// count lowered mid-vector: list cut to its best pairs
		write_reg(REG_KEEP_COUNT, 8);
		send_score(8'd50, 1'b0);
		send_score(8'd60, 1'b0);
		send_score(8'd70, 1'b0);
		send_score(8'd80, 1'b0);
		drain_results();
		write_reg(REG_KEEP_COUNT, 2);
		send_score(8'd10, 1'b1);
		drain_results();

		// score equal to the threshold passes, one below does not
		write_reg(REG_KEEP_COUNT, 1);
		write_reg(REG_THRESHOLD, 100);
		send_score(8'd99, 1'b0);
		send_score(8'd100, 1'b1);
		drain_results();

		// result side held off while vectors keep coming: the next last beat stalls
		write_reg(REG_THRESHOLD, 0);
		write_reg(REG_KEEP_COUNT, 8);
		rx_hold_cycles = 80;
		send_vector(6);
		send_vector(10);
		send_vector(5);
		drain_results();

		// random part in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
			recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 21 : 0;
			sent = 0;
			while (sent < 16) begin
				if ($urandom_range(2) == 0)
					random_settings();
				len = ($urandom_range(4) == 0) ? 1 : $urandom_range(12, 2);
				if (len > 1 && $urandom_range(5) == 0) begin
					// count changed part-way through the vector
					cut = $urandom_range(len - 1, 1);
					for (int i = 0; i < cut; i++)
						send_score(pick_score(), 1'b0);
					drain_results();
					write_reg(REG_KEEP_COUNT, $urandom_range(8));
					send_vector(len - cut);
				end else begin
					send_vector(len);
				end
				drain_results();
				sent += len;
			end
		end

		// back to the reset-like extremes once more
		write_reg(REG_KEEP_COUNT, 8);
		write_reg(REG_THRESHOLD, 0);
		send_vector(8);
		drain_results();
		repeat (20) @(negedge clk);

		if (mismatches == 0 && pending_results == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- thresholded_top_n_selector_core.f -----
hw/rtl/tts_pkg.sv
hw/rtl/tts_sort_cell.sv
hw/rtl/tts_out_cell.sv
hw/rtl/thresholded_top_n_selector_core.sv
dv/tts_result_checker.sv
dv/tb_thresholded_top_n_selector_core.sv
